// ===== sv/mrr_pkg.sv =====
// Shared types, register codes and message helpers for the MIDI rule router.
// Used by every module of the block; depends on nothing.
package mrr_pkg;

    localparam int RULE_SLOTS  = 4;
    localparam int RULE_REGS   = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W       = 3;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 50;
    localparam int CAT_W       = 9;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(RULE_SLOTS);

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RULE_COUNT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PORTS_EN     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SOFT_THRU    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_DROP_SENSING = 3'd7;

    localparam logic [3:0] PORTS_RESET = 4'h8;

    // Status high nibbles
    localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
    localparam logic [3:0] NIB_POLY_AT    = 4'hA;
    localparam logic [3:0] NIB_CTRL       = 4'hB;
    localparam logic [3:0] NIB_PROGRAM    = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT    = 4'hD;
    localparam logic [3:0] NIB_PITCH_BEND = 4'hE;
    localparam logic [3:0] NIB_SYSTEM     = 4'hF;

    // System status bytes
    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_CLOCK    = 8'hF8;
    localparam logic [7:0] ST_START    = 8'hFA;
    localparam logic [7:0] ST_CONTINUE = 8'hFB;
    localparam logic [7:0] ST_STOP     = 8'hFC;
    localparam logic [7:0] ST_SENSING  = 8'hFE;

    localparam logic [CAT_W-1:0] ALL_CATEGORIES = '1;
    localparam logic [7:0]       DATA_MAX       = 8'd127;

    typedef enum logic [1:0] {
        VERDICT_ROUTED = 2'd0,
        VERDICT_NONE   = 2'd1,
        VERDICT_DROP   = 2'd2
    } t_verdict;

    // Rule word, bit 0 is the enable
    typedef struct packed {
        logic [7:0]       transpose;
        logic [7:0]       offset;
        logic [15:0]      channels;
        logic [CAT_W-1:0] categories;
        logic [3:0]       dest;
        logic [3:0]       source;
        logic             enable;
    } t_rule;

    // Input tdata image, source port in the lowest bits
    typedef struct packed {
        logic [3:0] pad;
        logic [1:0] msg_length;
        logic [7:0] data_two;
        logic [7:0] data_one;
        logic [7:0] status_byte;
        logic [1:0] source_port;
    } t_in_item;

    // Output tdata image, dest ports in the lowest bits
    typedef struct packed {
        t_verdict   verdict;
        logic [1:0] length_out;
        logic [7:0] data_two_out;
        logic [7:0] data_one_out;
        logic [7:0] status_out;
        logic [3:0] dest_ports;
    } t_result;

    // Classified message waiting for the back end
    typedef struct packed {
        logic [RULE_SLOTS-1:0] hit;
        t_verdict              verdict;
        logic [3:0]            dest;
        logic [7:0]            status;
        logic [7:0]            data_one;
        logic [7:0]            data_two;
        logic [1:0]            msg_length;
    } t_entry;

    function automatic logic is_channel(input logic [7:0] st);
        is_channel = st[7] && (st[7:4] != NIB_SYSTEM);
    endfunction

    function automatic logic [CAT_W-1:0] category_of(input logic [7:0] st);
        logic [CAT_W-1:0] c;
        c = '0;
        if (st[7]) begin
            case (st[7:4])
                NIB_NOTE_OFF, NIB_NOTE_ON: c[0] = 1'b1;
                NIB_POLY_AT, NIB_CHAN_AT:  c[1] = 1'b1;
                NIB_CTRL:                  c[2] = 1'b1;
                NIB_PROGRAM:               c[3] = 1'b1;
                NIB_PITCH_BEND:            c[4] = 1'b1;
                default: begin
                    case (st)
                        ST_SYSEX:                         c[5] = 1'b1;
                        ST_CLOCK:                         c[6] = 1'b1;
                        ST_START, ST_CONTINUE, ST_STOP:   c[7] = 1'b1;
                        ST_SENSING:                       c[8] = 1'b1;
                        default:                          c = '0;
                    endcase
                end
            endcase
        end
        category_of = c;
    endfunction

    // Channel part of a rule match; system and data bytes always pass
    function automatic logic chan_ok(input t_rule r, input logic [7:0] st);
        chan_ok = !is_channel(st) || r.channels[st[3:0]];
    endfunction

    // Add a signed transpose to a data byte, clamp to 0..127
    function automatic logic [7:0] transpose_clamp(input logic [7:0] d,
                                                   input logic [7:0] tr);
        logic signed [9:0] v;
        v = $signed({2'b00, d}) + $signed({{2{tr[7]}}, tr});
        if (v < 0)
            transpose_clamp = '0;
        else if (v > $signed({2'b00, DATA_MAX}))
            transpose_clamp = DATA_MAX;
        else
            transpose_clamp = v[7:0];
    endfunction

endpackage

// ===== sv/mrr_front.sv =====
// Front end of the MIDI rule router: matches an arriving message against the rules.
// Produces the destination mask, verdict and per-rule hit bits. Depends on mrr_pkg.
module mrr_front
    import mrr_pkg::*;
(
    input  t_rule [RULE_SLOTS-1:0] i_rules,
    input  logic [CNT_W-1:0]       i_rule_count,
    input  logic [3:0]             i_ports_en,
    input  logic                   i_soft_thru,
    input  logic                   i_drop_sensing,
    input  t_in_item               i_item,
    output t_entry                 o_entry
);

    logic [CNT_W-1:0]      active;
    logic [3:0]            srcbit;
    logic [CAT_W-1:0]      cat;
    logic [RULE_SLOTS-1:0] hit;
    logic [3:0]            dest;

    assign active = (i_rule_count > SLOTS_CNT) ? SLOTS_CNT : i_rule_count;
    assign srcbit = 4'b0001 << i_item.source_port;
    assign cat    = category_of(i_item.status_byte);

    // Static part of each match: enable, source, category, slot in use
    always_comb begin
        for (int i = 0; i < RULE_SLOTS; i++) begin
            hit[i] = i_rules[i].enable
                  && ((i_rules[i].source & srcbit) != 4'h0)
                  && ((i_rules[i].categories == ALL_CATEGORIES)
                      || ((i_rules[i].categories & cat) != '0))
                  && (CNT_W'(i) < active);
        end
    end

    always_comb begin
        dest = 4'h0;
        if (i_item.msg_length != 2'd0) begin
            for (int i = 0; i < RULE_SLOTS; i++) begin
                if (hit[i] && chan_ok(i_rules[i], i_item.status_byte))
                    dest = dest | i_rules[i].dest;
            end
            if (i_soft_thru)
                dest = dest | srcbit;
            else
                dest = dest & ~srcbit;
            dest = dest & i_ports_en;
        end
    end

    always_comb begin
        o_entry.hit        = hit;
        o_entry.status     = i_item.status_byte;
        o_entry.data_one   = i_item.data_one;
        o_entry.data_two   = i_item.data_two;
        o_entry.msg_length = i_item.msg_length;
        if (dest == 4'h0) begin
            o_entry.verdict = VERDICT_NONE;
            o_entry.dest    = 4'h0;
        end else if (i_drop_sensing && (i_item.status_byte == ST_SENSING)) begin
            o_entry.verdict = VERDICT_DROP;
            o_entry.dest    = 4'h0;
        end else begin
            o_entry.verdict = VERDICT_ROUTED;
            o_entry.dest    = dest;
        end
    end

endmodule

// ===== sv/mrr_queue.sv =====
// Short first-in first-out queue of classified messages between front and back end.
// Depth from QUEUE_DEPTH in mrr_pkg.
module mrr_queue
    import mrr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_data
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop)
            n_count = r_count + 1'b1;
        else if (!i_push && i_pop)
            n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push)
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (i_pop)
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ===== sv/mrr_back.sv =====
// Back end of the MIDI rule router: applies channel offsets and transposes in rule
// order and holds the result in an output register. Depends on mrr_pkg.
module mrr_back
    import mrr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_rule [RULE_SLOTS-1:0] i_rules,
    input  logic                   i_valid,
    input  t_entry                 i_entry,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_result                o_result
);

    logic    r_valid;
    t_result r_out;
    t_result n_out;
    logic [7:0] st;
    logic [7:0] d1;

    // Rule chain: each later rule sees the status as changed so far
    always_comb begin
        st = i_entry.status;
        d1 = i_entry.data_one;
        if (i_entry.verdict == VERDICT_ROUTED) begin
            for (int i = 0; i < RULE_SLOTS; i++) begin
                if (i_entry.hit[i] && chan_ok(i_rules[i], st)) begin
                    if ((i_rules[i].offset != 8'h0) && is_channel(st))
                        st[3:0] = st[3:0] + i_rules[i].offset[3:0];
                    if ((i_rules[i].transpose != 8'h0) && (i_entry.msg_length >= 2'd2)
                        && (st[7:4] inside {NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT}))
                        d1 = transpose_clamp(d1, i_rules[i].transpose);
                end
            end
        end
    end

    always_comb begin
        n_out.verdict      = i_entry.verdict;
        n_out.length_out   = i_entry.msg_length;
        n_out.data_two_out = i_entry.data_two;
        n_out.data_one_out = d1;
        n_out.status_out   = st;
        n_out.dest_ports   = i_entry.dest;
    end

    assign o_pop    = i_valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= 1'b0;
        else
            r_valid <= o_pop || (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_out <= n_out;
    end

endmodule

// ===== sv/midi_rule_router.sv =====
// Path: an accepted message is queued, then passes the rule chain into the output register.
// Throughput: one message per cycle while m_axis_tready holds; a two-entry queue between
// classifier and rule chain plus the output register let either side stall alone.
// Reset (synchronous, active low): rules cleared, rule count 0, ports enabled 4'h8,
// soft-thru and sensing drop off, queue and output register emptied.
module midi_rule_router
    import mrr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Message in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: source_port[1:0], status_byte[9:2], data_one[17:10], data_two[25:18],
    //        msg_length[27:26], zero fill[31:28]
    input  logic [31:0]           s_axis_tdata,
    // Routed result out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: dest_ports[3:0], status_out[11:4], data_one_out[19:12], data_two_out[27:20],
    //        length_out[29:28], verdict[31:30]
    output logic [31:0]           m_axis_tdata
);

    // Configuration registers; the user must write them only while the block is idle (not enforced)
    t_rule [RULE_SLOTS-1:0] r_rules;
    logic [CNT_W-1:0]       r_rule_count;
    logic [3:0]             r_ports_en;
    logic                   r_soft_thru;
    logic                   r_drop_sensing;

    t_entry  front_entry;
    t_entry  q_entry;
    logic    q_full, q_valid, q_pop;
    logic    push;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rules        <= '0;
            r_rule_count   <= '0;
            r_ports_en     <= PORTS_RESET;
            r_soft_thru    <= 1'b0;
            r_drop_sensing <= 1'b0;
        end else if (i_cfg_we) begin
            // Rule words: slots that exist take the write, others drop it
            for (int i = 0; i < RULE_SLOTS; i++) begin
                if ((i < RULE_REGS) && (i_cfg_addr == CFG_ADDR_W'(i)))
                    r_rules[i] <= t_rule'(i_cfg_wdata);
            end
            case (i_cfg_addr)
                REG_RULE_COUNT:   r_rule_count   <= i_cfg_wdata[CNT_W-1:0];
                REG_PORTS_EN:     r_ports_en     <= i_cfg_wdata[3:0];
                REG_SOFT_THRU:    r_soft_thru    <= i_cfg_wdata[0];
                REG_DROP_SENSING: r_drop_sensing <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Accept whenever the queue has room; the back end drains it every cycle it can
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && s_axis_tready;

    mrr_front u_front (
        .i_rules        (r_rules),
        .i_rule_count   (r_rule_count),
        .i_ports_en     (r_ports_en),
        .i_soft_thru    (r_soft_thru),
        .i_drop_sensing (r_drop_sensing),
        .i_item         (t_in_item'(s_axis_tdata)),
        .o_entry        (front_entry)
    );

    mrr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_entry)
    );

    mrr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rules  (r_rules),
        .i_valid  (q_valid),
        .i_entry  (q_entry),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = result;

    // A dropped message is always active sensing and goes nowhere
    a_drop_is_sensing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (result.verdict == VERDICT_DROP)
        |-> (result.dest_ports == 4'h0) && (result.status_out == ST_SENSING))
        else $error("dropped message is not active sensing or has destinations");

    // Routed means some destination; anything else means none
    a_dest_vs_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((result.verdict == VERDICT_ROUTED) == (result.dest_ports != 4'h0)))
        else $error("verdict and destination mask disagree");

    // An empty message is never routed
    a_empty_not_routed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (result.length_out == 2'd0) |-> (result.verdict == VERDICT_NONE))
        else $error("empty message routed");

endmodule
